@@ design/fvzp_pkg.sv @@
package fvzp_pkg;

  // Viewport words are signed Q8.23, carried as raw 32-bit patterns
  localparam int VIEW_W  = 32;
  localparam int DELTA_W = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic [VIEW_W-1:0]  view_t;
  typedef logic [DELTA_W-1:0] delta_t;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_REAL   = 2'd0,
    CFG_STEP_IMAG   = 2'd1,
    CFG_ORIGIN_REAL = 2'd2,
    CFG_ORIGIN_IMAG = 2'd3
  } cfg_idx_t;

  // Restore values loaded at reset
  localparam view_t RST_STEP_REAL   = 32'd39321;
  localparam view_t RST_STEP_IMAG   = 32'd34952;
  localparam view_t RST_ORIGIN_REAL = 32'hFF00_0000;
  localparam view_t RST_ORIGIN_IMAG = 32'd8388608;

endpackage

@@ design/fractal_view_zoom_pan.sv @@
// A word accepted into the input register moves on into the result register once that is free.
// One word per cycle while the result side is not stalled; the input register and the result register form a
// two-stage pipeline, and the whole viewport update fits in the pass between them.
// Reset (synchronous, rst_n low): pipeline emptied, cursor at 0/0, viewport and
// restore defaults loaded with their reset values.
module fractal_view_zoom_pan #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int PAN_SHIFT     = 8,
  localparam int XW = $clog2(SCREEN_WIDTH),
  localparam int YW = $clog2(SCREEN_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      cfg_we,
  input  logic [fvzp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  fvzp_pkg::view_t           cfg_wdata,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic                      in_left_button,
  input  logic                      in_right_button,
  input  logic                      in_middle_button,
  input  logic signed [fvzp_pkg::DELTA_W-1:0] in_delta_x,
  input  logic signed [fvzp_pkg::DELTA_W-1:0] in_delta_y,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [XW-1:0]             out_cursor_x,
  output logic [YW-1:0]             out_cursor_y,
  output logic                      out_zoom_in_flag,
  output logic                      out_zoom_out_flag,
  output logic                      out_pan_flag,
  output logic signed [fvzp_pkg::VIEW_W-1:0] out_step_real_out,
  output logic signed [fvzp_pkg::VIEW_W-1:0] out_step_imag_out,
  output logic signed [fvzp_pkg::VIEW_W-1:0] out_origin_real_out,
  output logic signed [fvzp_pkg::VIEW_W-1:0] out_origin_imag_out
);

  import fvzp_pkg::*;

  localparam int SXW = ((XW > DELTA_W) ? XW : DELTA_W) + 2;
  localparam int SYW = ((YW > DELTA_W) ? YW : DELTA_W) + 2;
  localparam view_t HALF_W = view_t'(SCREEN_WIDTH / 2);
  localparam view_t HALF_H = view_t'(SCREEN_HEIGHT / 2);
  localparam logic [XW-1:0] X_MAX = XW'(SCREEN_WIDTH - 1);
  localparam logic [YW-1:0] Y_MAX = YW'(SCREEN_HEIGHT - 1);

  // Restore defaults
  view_t dflt_sr_r, dflt_si_r, dflt_or_r, dflt_oi_r;

  // Input stage
  logic         s1_valid_r;
  logic         s1_restore_r, s1_left_r, s1_right_r, s1_mid_r;
  logic signed [DELTA_W-1:0] s1_dx_r, s1_dy_r;
  logic         s1_adv;

  // Cursor and viewport state
  logic [XW-1:0] acc_x_r, acc_x_nxt;
  logic [YW-1:0] acc_y_r, acc_y_nxt;
  view_t step_real_r, step_imag_r, origin_real_r, origin_imag_r;
  view_t step_real_nxt, step_imag_nxt, origin_real_nxt, origin_imag_nxt;

  // Result register
  logic          out_valid_r;
  logic [XW-1:0] out_x_r;
  logic [YW-1:0] out_y_r;
  logic          out_zi_r, out_zo_r, out_pan_r;
  view_t         out_sr_r, out_si_r, out_or_r, out_oi_r;

  // Datapath
  logic signed [SXW-1:0] sum_x;
  logic signed [SYW-1:0] sum_y;
  logic [XW-1:0] clamp_x;
  logic [YW-1:0] clamp_y, yc;
  logic          left_en, right_en, mid_en;
  view_t xc32, yc32;
  view_t base_sr, base_si, base_or, base_oi;
  view_t sl_r, sl_i, sr_r, sr_i;
  view_t zi_or, zi_oi, zo_or, zo_oi;
  view_t ol_r, ol_i, orr, ori;
  view_t pan_r, pan_i;

  // Handshake: input stage moves on when the result register is free
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Capture restore defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_sr_r <= RST_STEP_REAL;
      dflt_si_r <= RST_STEP_IMAG;
      dflt_or_r <= RST_ORIGIN_REAL;
      dflt_oi_r <= RST_ORIGIN_IMAG;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_REAL:   dflt_sr_r <= cfg_wdata;
        CFG_STEP_IMAG:   dflt_si_r <= cfg_wdata;
        CFG_ORIGIN_REAL: dflt_or_r <= cfg_wdata;
        CFG_ORIGIN_IMAG: dflt_oi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_restore_r <= in_opcode;
      s1_left_r    <= in_left_button;
      s1_right_r   <= in_right_button;
      s1_mid_r     <= in_middle_button;
      s1_dx_r      <= in_delta_x;
      s1_dy_r      <= in_delta_y;
    end
  end

  // Move and clamp the cursor; hold it on restore
  always_comb begin
    sum_x = $signed(SXW'(acc_x_r)) + SXW'(s1_dx_r);
    sum_y = $signed(SYW'(acc_y_r)) + SYW'(s1_dy_r);
    if (sum_x < 0)                         clamp_x = '0;
    else if (sum_x > $signed(SXW'(X_MAX))) clamp_x = X_MAX;
    else                                   clamp_x = sum_x[XW-1:0];
    if (sum_y < 0)                         clamp_y = '0;
    else if (sum_y > $signed(SYW'(Y_MAX))) clamp_y = Y_MAX;
    else                                   clamp_y = sum_y[YW-1:0];
    acc_x_nxt = s1_restore_r ? acc_x_r : clamp_x;
    acc_y_nxt = s1_restore_r ? acc_y_r : clamp_y;
    yc        = Y_MAX - acc_y_nxt;
    xc32      = {{(VIEW_W-XW){1'b0}}, acc_x_nxt};
    yc32      = {{(VIEW_W-YW){1'b0}}, yc};
  end

  // Viewport update: restore, then zoom in, zoom out and edge pan in turn
  always_comb begin
    left_en  = !s1_restore_r && s1_left_r;
    right_en = !s1_restore_r && s1_right_r;
    mid_en   = !s1_restore_r && s1_mid_r;

    base_sr = s1_restore_r ? dflt_sr_r : step_real_r;
    base_si = s1_restore_r ? dflt_si_r : step_imag_r;
    base_or = s1_restore_r ? dflt_or_r : origin_real_r;
    base_oi = s1_restore_r ? dflt_oi_r : origin_imag_r;

    // Zoom in: halve steps, re-center at cursor
    sl_r  = left_en ? {base_sr[VIEW_W-1], base_sr[VIEW_W-1:1]} : base_sr;
    sl_i  = left_en ? {base_si[VIEW_W-1], base_si[VIEW_W-1:1]} : base_si;
    zi_or = base_or + xc32 * {sl_r[VIEW_W-2:0], 1'b0} - sl_r * HALF_W;
    zi_oi = base_oi - yc32 * {sl_i[VIEW_W-2:0], 1'b0} + sl_i * HALF_H;
    ol_r  = left_en ? zi_or : base_or;
    ol_i  = left_en ? zi_oi : base_oi;

    // Zoom out: double steps and move the origin
    sr_r  = right_en ? {sl_r[VIEW_W-2:0], 1'b0} : sl_r;
    sr_i  = right_en ? {sl_i[VIEW_W-2:0], 1'b0} : sl_i;
    zo_or = ol_r + xc32 * {sr_r[VIEW_W-1], sr_r[VIEW_W-1:1]} - sr_r * HALF_W;
    zo_oi = ol_i - yc32 * {sr_i[VIEW_W-1], sr_i[VIEW_W-1:1]} + sr_i * HALF_H;
    orr   = right_en ? zo_or : ol_r;
    ori   = right_en ? zo_oi : ol_i;

    // Edge pan
    pan_r = sr_r << PAN_SHIFT;
    pan_i = sr_i << PAN_SHIFT;
    origin_real_nxt = orr
                    + ((mid_en && acc_x_nxt == X_MAX) ? pan_r : '0)
                    - ((mid_en && acc_x_nxt == '0)    ? pan_r : '0);
    origin_imag_nxt = ori
                    + ((mid_en && yc == '0)    ? pan_i : '0)
                    - ((mid_en && yc == Y_MAX) ? pan_i : '0);
    step_real_nxt = sr_r;
    step_imag_nxt = sr_i;
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r       <= '0;
      acc_y_r       <= '0;
      step_real_r   <= RST_STEP_REAL;
      step_imag_r   <= RST_STEP_IMAG;
      origin_real_r <= RST_ORIGIN_REAL;
      origin_imag_r <= RST_ORIGIN_IMAG;
    end else if (s1_adv) begin
      acc_x_r       <= acc_x_nxt;
      acc_y_r       <= acc_y_nxt;
      step_real_r   <= step_real_nxt;
      step_imag_r   <= step_imag_nxt;
      origin_real_r <= origin_real_nxt;
      origin_imag_r <= origin_imag_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_x_r   <= acc_x_nxt;
      out_y_r   <= yc;
      out_zi_r  <= left_en;
      out_zo_r  <= right_en;
      out_pan_r <= mid_en;
      out_sr_r  <= step_real_nxt;
      out_si_r  <= step_imag_nxt;
      out_or_r  <= origin_real_nxt;
      out_oi_r  <= origin_imag_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_x        = out_x_r;
  assign out_cursor_y        = out_y_r;
  assign out_zoom_in_flag    = out_zi_r;
  assign out_zoom_out_flag   = out_zo_r;
  assign out_pan_flag        = out_pan_r;
  assign out_step_real_out   = $signed(out_sr_r);
  assign out_step_imag_out   = $signed(out_si_r);
  assign out_origin_real_out = $signed(out_or_r);
  assign out_origin_imag_out = $signed(out_oi_r);

endmodule

@@ design/fvzp_check.sv @@
module fvzp_check #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  localparam int XW = $clog2(SCREEN_WIDTH),
  localparam int YW = $clog2(SCREEN_HEIGHT)
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [XW-1:0]   out_cursor_x,
  input logic [YW-1:0]   out_cursor_y,
  input fvzp_pkg::view_t out_step_real_out,
  input fvzp_pkg::view_t out_origin_real_out
);

  import fvzp_pkg::*;

  localparam logic [XW-1:0] X_MAX = XW'(SCREEN_WIDTH - 1);
  localparam logic [YW-1:0] Y_MAX = YW'(SCREEN_HEIGHT - 1);

  // Reset empties the pipeline and opens the input side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // Input side only stalls behind a stalled result word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // Cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_x <= X_MAX && out_cursor_y <= Y_MAX)
    else $error("cursor off screen");

  // Blocked result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_real_out)
      && $stable(out_origin_real_out) && $stable(out_cursor_x))
    else $error("result word changed while blocked");

endmodule

bind fractal_view_zoom_pan fvzp_check #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_fvzp_check (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_cursor_x        (out_cursor_x),
  .out_cursor_y        (out_cursor_y),
  .out_step_real_out   (out_step_real_out),
  .out_origin_real_out (out_origin_real_out)
);

@@ bench/tb_fractal_view_zoom_pan.sv @@
module tb_fractal_view_zoom_pan;
  timeunit 1ns;
  timeprecision 1ps;

  import fvzp_pkg::*;

  localparam logic OP_MOUSE   = 1'b0;
  localparam logic OP_RESTORE = 1'b1;

  localparam int    X_MAX     = 639;
  localparam int    Y_MAX     = 479;
  localparam view_t HALF_W    = 32'd320;
  localparam view_t HALF_H    = 32'd240;
  localparam int    PAN_SHIFT = 8;

  typedef struct packed {
    logic                       opcode;
    logic                       left;
    logic                       right;
    logic                       middle;
    logic signed [DELTA_W-1:0]  delta_x;
    logic signed [DELTA_W-1:0]  delta_y;
  } mouse_word_t;

  typedef struct packed {
    logic [9:0] cursor_x;
    logic [8:0] cursor_y;
    logic       zoom_in;
    logic       zoom_out;
    logic       pan;
    view_t      step_real;
    view_t      step_imag;
    view_t      origin_real;
    view_t      origin_imag;
  } view_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic            cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STEP_REAL;
  view_t           cfg_wdata = '0;

  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_opcode = OP_MOUSE;
  logic            in_left_button = 1'b0;
  logic            in_right_button = 1'b0;
  logic            in_middle_button = 1'b0;
  logic signed [DELTA_W-1:0] in_delta_x = '0;
  logic signed [DELTA_W-1:0] in_delta_y = '0;

  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [9:0]      out_cursor_x;
  logic [8:0]      out_cursor_y;
  logic            out_zoom_in_flag;
  logic            out_zoom_out_flag;
  logic            out_pan_flag;
  logic signed [VIEW_W-1:0] out_step_real_out;
  logic signed [VIEW_W-1:0] out_step_imag_out;
  logic signed [VIEW_W-1:0] out_origin_real_out;
  logic signed [VIEW_W-1:0] out_origin_imag_out;

  fractal_view_zoom_pan uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_left_button      (in_left_button),
    .in_right_button     (in_right_button),
    .in_middle_button    (in_middle_button),
    .in_delta_x          (in_delta_x),
    .in_delta_y          (in_delta_y),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cursor_x        (out_cursor_x),
    .out_cursor_y        (out_cursor_y),
    .out_zoom_in_flag    (out_zoom_in_flag),
    .out_zoom_out_flag   (out_zoom_out_flag),
    .out_pan_flag        (out_pan_flag),
    .out_step_real_out   (out_step_real_out),
    .out_step_imag_out   (out_step_imag_out),
    .out_origin_real_out (out_origin_real_out),
    .out_origin_imag_out (out_origin_imag_out)
  );

  always #4 clk = ~clk;

  // Viewport tracker state, mirrors the block after reset
  int    cur_x = 0;
  int    cur_y = 0;
  view_t step_re = RST_STEP_REAL;
  view_t step_im = RST_STEP_IMAG;
  view_t org_re  = RST_ORIGIN_REAL;
  view_t org_im  = RST_ORIGIN_IMAG;
  view_t dflt_step_re = RST_STEP_REAL;
  view_t dflt_step_im = RST_STEP_IMAG;
  view_t dflt_org_re  = RST_ORIGIN_REAL;
  view_t dflt_org_im  = RST_ORIGIN_IMAG;

  mouse_word_t  mouse_words[$];
  view_result_t pending_views[$];
  mouse_word_t  held_word = '0;
  mouse_word_t  next_word;
  int send_idle_pct = 22;
  int recv_idle_pct = 47;
  int mismatches = 0;

  function automatic view_t asr1(view_t v);
    return {v[VIEW_W-1], v[VIEW_W-1:1]};
  endfunction

  // Apply one word to the tracked viewport and return the result it yields
  function automatic view_result_t advance_viewport(mouse_word_t w);
    view_result_t r;
    view_t xc;
    view_t yc;
    logic zin;
    logic zout;
    logic pan;
    zin  = w.left;
    zout = w.right;
    pan  = w.middle;
    if (w.opcode == OP_RESTORE) begin
      step_re = dflt_step_re;
      step_im = dflt_step_im;
      org_re  = dflt_org_re;
      org_im  = dflt_org_im;
      zin  = 1'b0;
      zout = 1'b0;
      pan  = 1'b0;
    end else begin
      cur_x = cur_x + $signed(w.delta_x);
      cur_y = cur_y + $signed(w.delta_y);
      if (cur_x < 0) cur_x = 0;
      else if (cur_x > X_MAX) cur_x = X_MAX;
      if (cur_y < 0) cur_y = 0;
      else if (cur_y > Y_MAX) cur_y = Y_MAX;
    end
    xc = cur_x;
    yc = Y_MAX - cur_y;

    // Zoom in: halve steps, re-center on the cursor
    if (zin) begin
      step_im = asr1(step_im);
      step_re = asr1(step_re);
      org_im = org_im - yc * (step_im << 1) + step_im * HALF_H;
      org_re = org_re + xc * (step_re << 1) - step_re * HALF_W;
    end
    // Zoom out: double steps, keep the lopsided origin update
    if (zout) begin
      step_im = step_im << 1;
      step_re = step_re << 1;
      org_im = org_im - yc * asr1(step_im) + step_im * HALF_H;
      org_re = org_re + xc * asr1(step_re) - step_re * HALF_W;
    end
    // Edge pan only when the cursor sits on a screen border
    if (pan) begin
      if (xc == 0) org_re = org_re - (step_re << PAN_SHIFT);
      if (xc == X_MAX) org_re = org_re + (step_re << PAN_SHIFT);
      if (yc == 0) org_im = org_im + (step_im << PAN_SHIFT);
      if (yc == Y_MAX) org_im = org_im - (step_im << PAN_SHIFT);
    end

    r.cursor_x    = xc[9:0];
    r.cursor_y    = yc[8:0];
    r.zoom_in     = zin;
    r.zoom_out    = zout;
    r.pan         = pan;
    r.step_real   = step_re;
    r.step_imag   = step_im;
    r.origin_real = org_re;
    r.origin_imag = org_im;
    return r;
  endfunction

  // Driver: record accepted word, then offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) pending_views.push_back(advance_viewport(held_word));
      if (!in_valid || in_ready) begin
        if (mouse_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = mouse_words.pop_front();
          held_word        <= next_word;
          in_valid         <= 1'b1;
          in_opcode        <= next_word.opcode;
          in_left_button   <= next_word.left;
          in_right_button  <= next_word.right;
          in_middle_button <= next_word.middle;
          in_delta_x       <= next_word.delta_x;
          in_delta_y       <= next_word.delta_y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Monitor: compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    view_result_t exp_view;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_views.size() == 0) begin
          $display("%0t unexpected result word: cursor %0d/%0d", $time,
                   out_cursor_x, out_cursor_y);
          mismatches++;
        end else begin
          exp_view = pending_views.pop_front();
          check_field("cursor_x", exp_view.cursor_x, out_cursor_x);
          check_field("cursor_y", exp_view.cursor_y, out_cursor_y);
          check_field("zoom_in_flag", exp_view.zoom_in, out_zoom_in_flag);
          check_field("zoom_out_flag", exp_view.zoom_out, out_zoom_out_flag);
          check_field("pan_flag", exp_view.pan, out_pan_flag);
          check_field("step_real_out", exp_view.step_real, out_step_real_out);
          check_field("step_imag_out", exp_view.step_imag, out_step_imag_out);
          check_field("origin_real_out", exp_view.origin_real, out_origin_real_out);
          check_field("origin_imag_out", exp_view.origin_imag, out_origin_imag_out);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_word(logic op, logic l, logic r, logic m,
                            logic signed [DELTA_W-1:0] dx,
                            logic signed [DELTA_W-1:0] dy);
    mouse_word_t w;
    w.opcode  = op;
    w.left    = l;
    w.right   = r;
    w.middle  = m;
    w.delta_x = dx;
    w.delta_y = dy;
    mouse_words.push_back(w);
  endtask

  // Random packets, biased so the cursor keeps hitting the screen borders
  task automatic queue_random_words(int count);
    mouse_word_t w;
    for (int i = 0; i < count; i++) begin
      w.opcode = ($urandom_range(99) < 6) ? OP_RESTORE : OP_MOUSE;
      w.left   = ($urandom_range(99) < 30);
      w.right  = ($urandom_range(99) < 30);
      w.middle = ($urandom_range(99) < 35);
      if ($urandom_range(3) == 0) w.delta_x = $urandom_range(1) ? 8'sd127 : -8'sd128;
      else w.delta_x = DELTA_W'($urandom);
      if ($urandom_range(3) == 0) w.delta_y = $urandom_range(1) ? 8'sd127 : -8'sd128;
      else w.delta_y = DELTA_W'($urandom);
      mouse_words.push_back(w);
    end
  endtask

  // Hold until every word is sent and every result has come back
  task automatic wait_view_settled();
    @(negedge clk);
    while (mouse_words.size() != 0 || in_valid || pending_views.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, view_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP_REAL:   dflt_step_re = val;
      CFG_STEP_IMAG:   dflt_step_im = val;
      CFG_ORIGIN_REAL: dflt_org_re  = val;
      CFG_ORIGIN_IMAG: dflt_org_im  = val;
      default: ;
    endcase
  endtask

  // Stimulus sequence
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset corner, clamps, each button, opposite corner, restore
    queue_word(OP_MOUSE, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0);
    queue_word(OP_MOUSE, 1'b0, 1'b0, 1'b1, -8'sd128, -8'sd128);
    queue_word(OP_MOUSE, 1'b1, 1'b0, 1'b0, 8'sd0, 8'sd0);
    queue_word(OP_MOUSE, 1'b0, 1'b1, 1'b0, 8'sd0, 8'sd0);
    queue_word(OP_MOUSE, 1'b1, 1'b1, 1'b0, 8'sd0, 8'sd0);
    for (int i = 0; i < 4; i++) queue_word(OP_MOUSE, 1'b0, 1'b0, 1'b0, 8'sd127, 8'sd127);
    queue_word(OP_MOUSE, 1'b0, 1'b0, 1'b1, 8'sd127, 8'sd127);
    queue_word(OP_MOUSE, 1'b0, 1'b0, 1'b1, 8'sd127, 8'sd127);
    queue_word(OP_MOUSE, 1'b1, 1'b1, 1'b1, 8'sd0, 8'sd0);
    queue_word(OP_RESTORE, 1'b1, 1'b1, 1'b1, 8'sd5, -8'sd7);
    queue_word(OP_MOUSE, 1'b1, 1'b0, 1'b0, 8'sd1, -8'sd1);
    queue_word(OP_MOUSE, 1'b0, 1'b0, 1'b1, -8'sd128, 8'sd0);
    queue_word(OP_MOUSE, 1'b0, 1'b1, 1'b0, 8'sd127, -8'sd128);
    wait_view_settled();

    // Random phases, each under its own restore defaults
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_STEP_REAL, 32'h8000_0000);
          write_reg(CFG_STEP_IMAG, 32'h7FFF_FFFF);
          write_reg(CFG_ORIGIN_REAL, 32'h0000_0000);
          write_reg(CFG_ORIGIN_IMAG, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_STEP_REAL, 32'h7FFF_FFFF);
          write_reg(CFG_STEP_IMAG, 32'h8000_0000);
          write_reg(CFG_ORIGIN_REAL, 32'hFFFF_FFFF);
          write_reg(CFG_ORIGIN_IMAG, 32'h0000_0000);
        end
        2: begin
          write_reg(CFG_STEP_REAL, $urandom);
          write_reg(CFG_STEP_IMAG, $urandom);
          write_reg(CFG_ORIGIN_REAL, $urandom);
          write_reg(CFG_ORIGIN_IMAG, $urandom);
        end
        3: begin
          write_reg(CFG_STEP_REAL, $urandom_range(65535, 1));
          write_reg(CFG_STEP_IMAG, $urandom_range(65535, 1));
          write_reg(CFG_ORIGIN_REAL, $urandom);
          write_reg(CFG_ORIGIN_IMAG, $urandom);
        end
        default: begin
          write_reg(CFG_STEP_REAL, RST_STEP_REAL);
          write_reg(CFG_STEP_IMAG, RST_STEP_IMAG);
          write_reg(CFG_ORIGIN_REAL, RST_ORIGIN_REAL);
          write_reg(CFG_ORIGIN_IMAG, RST_ORIGIN_IMAG);
        end
      endcase
      @(negedge clk);
      if (phase < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 47;
      end else if (phase < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_word(OP_RESTORE, 1'b0, 1'b0, 1'b0, 8'sd0, 8'sd0);
      queue_random_words(380);
      wait_view_settled();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
